/* src/lebc_pkg.sv */
package lebc_pkg;

    typedef enum logic [2:0] {
        CMD_COMMIT    = 3'd0,
        CMD_CANCEL    = 3'd1,
        CMD_BACKSPACE = 3'd2,
        CMD_DELETE    = 3'd3,
        CMD_LEFT      = 3'd4,
        CMD_RIGHT     = 3'd5,
        CMD_INSERT    = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SHIFT_OUT
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    localparam logic [7:0] CHAR_LOW  = 8'd32;
    localparam logic [7:0] CHAR_HIGH = 8'd127;

endpackage

/* src/lebc_cmd_if.sv */
interface lebc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] key_char;

    modport source (output valid, output cmd, output key_char, input ready);
    modport sink (input valid, input cmd, input key_char, output ready);
endinterface

/* src/lebc_res_if.sv */
interface lebc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       team;
    logic       empty_line;
    logic       last;

    modport source (output valid, output out_char, output team, output empty_line,
                    output last, input ready);
    modport sink (input valid, input out_char, input team, input empty_line,
                  input last, output ready);
endinterface

/* src/lebc_cfg_if.sv */
interface lebc_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/lebc_cell.sv */
module lebc_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 6
) (
    input  logic                clk,
    input  lebc_pkg::cell_op_t  op,
    input  logic [PW-1:0]       pos,
    input  logic [7:0]          left_char,
    input  logic [7:0]          right_char,
    input  logic [7:0]          new_char,
    output logic [7:0]          q
);

    localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

    logic [7:0] char_reg;
    logic [7:0] char_next;

    always_comb
    begin
        char_next = char_reg;
        case (op)
            lebc_pkg::CELL_INSERT:
            begin
                if (MY_INDEX == pos)
                    char_next = new_char;
                else if (MY_INDEX > pos)
                    char_next = left_char;
            end
            lebc_pkg::CELL_REMOVE:
            begin
                if (MY_INDEX >= pos)
                    char_next = right_char;
            end
            lebc_pkg::CELL_SHIFT_OUT:
                char_next = right_char;
            default:
                char_next = char_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign q = char_reg;

endmodule

/* src/line_edit_buffer_with_cursor.sv */
// An edit command is applied when it is accepted; the next word is accepted in the following cycle.
// Commit: the state register enters emit, then the first character is loaded into the output register,
// then one character per cycle as the sink takes them; an empty line gives a single word.
// Input is not ready while the line streams out of the cell row's head.
// Reset clears length, cursor, team flag, state and output valid; character cells hold
// whatever they had and are only read below the line length.
module line_edit_buffer_with_cursor #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    lebc_cmd_if.sink     key_in,
    lebc_res_if.source   line_out,
    lebc_cfg_if.sink     cfg
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam logic [PW-1:0] LEN_MAX = PW'(BUFFER_DEPTH - 1);
    localparam logic [PW-1:0] ONE     = PW'(1);

    lebc_pkg::state_t state_reg, state_next;

    logic [PW-1:0] len_reg, len_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic          empty_reg, empty_next;
    logic          team_mode_reg;
    logic          team_reg, team_next;

    logic          res_valid_reg, res_valid_next;
    logic [7:0]    res_char_reg;
    logic          res_team_reg;
    logic          res_empty_reg;
    logic          res_last_reg;

    logic                 accept;
    logic                 load_out;
    logic                 emit_last;
    logic                 char_ok;
    lebc_pkg::cell_op_t   cell_op;
    logic [PW-1:0]        cell_pos;
    logic [7:0]           cell_q [BUFFER_DEPTH];

    assign accept    = key_in.valid && key_in.ready;
    assign char_ok   = (key_in.key_char >= lebc_pkg::CHAR_LOW) &&
                       (key_in.key_char <= lebc_pkg::CHAR_HIGH);
    assign emit_last = empty_reg || (rem_reg == ONE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lebc_pkg::ST_IDLE:
            begin
                if (accept && key_in.cmd == lebc_pkg::CMD_COMMIT)
                    state_next = lebc_pkg::ST_EMIT;
            end
            lebc_pkg::ST_EMIT:
            begin
                if (load_out && emit_last)
                    state_next = lebc_pkg::ST_IDLE;
            end
            default:
                state_next = lebc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        key_in.ready = (state_reg == lebc_pkg::ST_IDLE);
        load_out     = (state_reg == lebc_pkg::ST_EMIT) &&
                       (!res_valid_reg || line_out.ready);
        cell_op      = lebc_pkg::CELL_HOLD;
        cell_pos     = len_reg - cur_reg;
        len_next     = len_reg;
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        empty_next   = empty_reg;
        team_next    = team_reg;

        if (accept)
        begin
            unique case (key_in.cmd)
                lebc_pkg::CMD_COMMIT:
                begin
                    rem_next   = len_reg;
                    empty_next = (len_reg == '0);
                    team_next  = team_mode_reg;
                    len_next   = '0;
                    cur_next   = '0;
                end
                lebc_pkg::CMD_CANCEL:
                begin
                    len_next = '0;
                    cur_next = '0;
                end
                lebc_pkg::CMD_BACKSPACE:
                begin
                    cell_pos = len_reg - cur_reg - ONE;
                    if (len_reg != '0 && cur_reg < len_reg)
                    begin
                        cell_op  = lebc_pkg::CELL_REMOVE;
                        len_next = len_reg - ONE;
                    end
                end
                lebc_pkg::CMD_DELETE:
                begin
                    if (len_reg != '0 && cur_reg != '0)
                    begin
                        cell_op  = lebc_pkg::CELL_REMOVE;
                        len_next = len_reg - ONE;
                        cur_next = cur_reg - ONE;
                    end
                end
                lebc_pkg::CMD_LEFT:
                begin
                    if (len_reg != '0 && cur_reg < len_reg)
                        cur_next = cur_reg + ONE;
                end
                lebc_pkg::CMD_RIGHT:
                begin
                    if (len_reg != '0 && cur_reg != '0)
                        cur_next = cur_reg - ONE;
                end
                lebc_pkg::CMD_INSERT:
                begin
                    if (char_ok && len_reg < LEN_MAX)
                    begin
                        cell_op  = lebc_pkg::CELL_INSERT;
                        len_next = len_reg + ONE;
                    end
                end
                default:
                    cell_op = lebc_pkg::CELL_HOLD;
            endcase
        end
        else if (load_out)
        begin
            // advance the row so the next character sits at the head
            if (!empty_reg)
                cell_op = lebc_pkg::CELL_SHIFT_OUT;
            rem_next = rem_reg - ONE;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_out)
            res_valid_next = 1'b1;
        else if (line_out.ready)
            res_valid_next = 1'b0;
    end

    genvar g;
    generate
        for (g = 0; g < BUFFER_DEPTH; g++)
        begin : g_cell
            logic [7:0] left_c;
            logic [7:0] right_c;
            if (g == 0)
            begin : g_first
                assign left_c = key_in.key_char;
            end
            else
            begin : g_mid
                assign left_c = cell_q[g-1];
            end
            if (g == BUFFER_DEPTH - 1)
            begin : g_end
                assign right_c = cell_q[g];
            end
            else
            begin : g_body
                assign right_c = cell_q[g+1];
            end
            lebc_cell #(
                .INDEX (g),
                .PW    (PW)
            ) u_cell (
                .clk        (clk),
                .op         (cell_op),
                .pos        (cell_pos),
                .left_char  (left_c),
                .right_char (right_c),
                .new_char   (key_in.key_char),
                .q          (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lebc_pkg::ST_IDLE;
            len_reg       <= '0;
            cur_reg       <= '0;
            rem_reg       <= '0;
            empty_reg     <= 1'b0;
            team_reg      <= 1'b0;
            team_mode_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            rem_reg       <= rem_next;
            empty_reg     <= empty_next;
            team_reg      <= team_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
                team_mode_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_char_reg  <= empty_reg ? 8'd0 : cell_q[0];
            res_team_reg  <= team_reg;
            res_empty_reg <= empty_reg;
            res_last_reg  <= emit_last;
        end
    end

    assign cfg.ready           = 1'b1;
    assign line_out.valid      = res_valid_reg;
    assign line_out.out_char   = res_char_reg;
    assign line_out.team       = res_team_reg;
    assign line_out.empty_line = res_empty_reg;
    assign line_out.last       = res_last_reg;

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= len_reg)
        else $error("cursor beyond line end");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("line length beyond buffer");

    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && emit_last) |=> (state_reg == lebc_pkg::ST_IDLE))
        else $error("emission continued past last word");

    a_commit_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && key_in.cmd == lebc_pkg::CMD_COMMIT) |=>
            (state_reg == lebc_pkg::ST_EMIT && len_reg == '0))
        else $error("commit did not start emission");

    a_emit_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lebc_pkg::ST_EMIT) |-> (empty_reg || rem_reg != '0))
        else $error("emission with nothing left");

endmodule

/* verif/tb_line_edit_buffer_with_cursor.sv */
`timescale 1ns / 1ps

module tb_line_edit_buffer_with_cursor;

    localparam int BUFFER_DEPTH = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] ch;
        logic       team;
        logic       empty_line;
        logic       last;
    } line_char_t;

    class line_echo_check;
        logic [7:0] text [BUFFER_DEPTH];
        logic [6:0] len;
        logic [6:0] back;
        logic       team_flag;
        line_char_t due_chars [$];
        int         fail_count;

        function new();
            len = '0;
            back = '0;
            team_flag = 1'b0;
            fail_count = 0;
        endfunction

        function void set_team(logic v);
            team_flag = v;
        endfunction

        function void remove_at(int pos);
            int i;
            for (i = pos; i + 1 < len; i++)
                text[i] = text[i + 1];
            len = len - 7'd1;
        endfunction

        function void take_key(logic [2:0] c, logic [7:0] k);
            line_char_t r;
            int i;
            int pos;
            case (c)
                lebc_pkg::CMD_COMMIT:
                begin
                    if (len == 0)
                    begin
                        r = '{ch: 8'd0, team: team_flag, empty_line: 1'b1, last: 1'b1};
                        due_chars.push_back(r);
                    end
                    else
                    begin
                        for (i = 0; i < len; i++)
                        begin
                            r = '{ch: text[i], team: team_flag, empty_line: 1'b0,
                                  last: (i + 1 == len)};
                            due_chars.push_back(r);
                        end
                    end
                    len = '0;
                    back = '0;
                end
                lebc_pkg::CMD_CANCEL:
                begin
                    len = '0;
                    back = '0;
                end
                lebc_pkg::CMD_BACKSPACE:
                    if (len != 0 && back < len)
                        remove_at(len - back - 1);
                lebc_pkg::CMD_DELETE:
                    if (len != 0 && back != 0)
                    begin
                        remove_at(len - back);
                        back = back - 7'd1;
                    end
                lebc_pkg::CMD_LEFT:
                    if (len != 0 && back < len)
                        back = back + 7'd1;
                lebc_pkg::CMD_RIGHT:
                    if (len != 0 && back != 0)
                        back = back - 7'd1;
                lebc_pkg::CMD_INSERT:
                    if (k >= lebc_pkg::CHAR_LOW && k <= lebc_pkg::CHAR_HIGH &&
                        len < BUFFER_DEPTH - 1)
                    begin
                        pos = len - back;
                        for (i = len; i > pos; i--)
                            text[i] = text[i - 1];
                        text[pos] = k;
                        len = len + 7'd1;
                    end
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            fail_count++;
        endtask

        task check_char(logic [7:0] ch, logic team, logic empty_line, logic last);
            line_char_t want;
            if (due_chars.size() == 0)
            begin
                report($sformatf("unexpected word, char %0d last %0b", ch, last));
                return;
            end
            want = due_chars.pop_front();
            if (empty_line !== want.empty_line)
                report($sformatf("empty_line %0b, want %0b", empty_line, want.empty_line));
            if (!want.empty_line && ch !== want.ch)
                report($sformatf("out_char %0d, want %0d", ch, want.ch));
            if (team !== want.team)
                report($sformatf("team %0b, want %0b", team, want.team));
            if (last !== want.last)
                report($sformatf("last %0b, want %0b", last, want.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct = 15;
    bit   hold_req = 1'b0;
    int   quiet_cycles = 0;
    line_echo_check sb = new();

    lebc_cmd_if key_if ();
    lebc_res_if res_if ();
    lebc_cfg_if cfg_if ();

    line_edit_buffer_with_cursor #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .key_in(key_if),
        .line_out(res_if),
        .cfg(cfg_if)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((key_if.valid && key_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : result_sink
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                sb.check_char(res_if.out_char, res_if.team, res_if.empty_line, res_if.last);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_key(input logic [2:0] c, input logic [7:0] k);
        while ($urandom_range(99) < idle_pct)
        begin
            key_if.valid <= 1'b0;
            @(posedge clk);
        end
        key_if.valid <= 1'b1;
        key_if.cmd <= c;
        key_if.key_char <= k;
        @(posedge clk);
        while (!key_if.ready)
            @(posedge clk);
        sb.take_key(c, k);
    endtask

    task automatic write_team(input logic v);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.set_team(v);
        cfg_if.valid <= 1'b0;
    endtask

    // drop valid, wait out every due word, then let the last command finish
    task automatic settle();
        key_if.valid <= 1'b0;
        while (sb.due_chars.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic pick_key(output logic [2:0] c, output logic [7:0] k);
        int r;
        r = $urandom_range(99);
        k = 8'($urandom_range(255));
        if (r < 50)
        begin
            c = lebc_pkg::CMD_INSERT;
            k = 8'($urandom_range(lebc_pkg::CHAR_HIGH, lebc_pkg::CHAR_LOW));
        end
        else if (r < 55)
            c = lebc_pkg::CMD_INSERT;
        else if (r < 63)
            c = lebc_pkg::CMD_LEFT;
        else if (r < 69)
            c = lebc_pkg::CMD_RIGHT;
        else if (r < 76)
            c = lebc_pkg::CMD_BACKSPACE;
        else if (r < 83)
            c = lebc_pkg::CMD_DELETE;
        else if (r < 85)
            c = lebc_pkg::CMD_CANCEL;
        else if (r < 94)
            c = lebc_pkg::CMD_COMMIT;
        else if (r < 96)
            c = CMD_UNUSED;
        else
        begin
            c = lebc_pkg::CMD_INSERT;
            k = 8'($urandom_range(lebc_pkg::CHAR_HIGH, lebc_pkg::CHAR_LOW));
        end
    endtask

    // overfill the line, moving the cursor now and then, and commit it
    task automatic fill_line();
        repeat (BUFFER_DEPTH + 6)
        begin
            if ($urandom_range(9) == 0)
                send_key(lebc_pkg::CMD_LEFT, 8'($urandom_range(255)));
            else
                send_key(lebc_pkg::CMD_INSERT,
                         8'($urandom_range(lebc_pkg::CHAR_HIGH, lebc_pkg::CHAR_LOW)));
        end
        send_key(lebc_pkg::CMD_COMMIT, 8'($urandom_range(255)));
    endtask

    initial
    begin : stimulus
        logic [2:0] c;
        logic [7:0] k;
        logic       team_plan [5];
        team_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        rst_n <= 1'b0;
        key_if.valid <= 1'b0;
        key_if.cmd <= lebc_pkg::CMD_COMMIT;
        key_if.key_char <= 8'd0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_team(1'b0);

        send_key(lebc_pkg::CMD_COMMIT, 8'd0);
        send_key(lebc_pkg::CMD_BACKSPACE, 8'd65);
        send_key(lebc_pkg::CMD_DELETE, 8'd66);
        send_key(lebc_pkg::CMD_LEFT, 8'd67);
        send_key(lebc_pkg::CMD_RIGHT, 8'd68);
        send_key(CMD_UNUSED, 8'd69);
        send_key(lebc_pkg::CMD_INSERT, 8'd31);
        send_key(lebc_pkg::CMD_INSERT, 8'd128);
        send_key(lebc_pkg::CMD_INSERT, 8'd0);
        send_key(lebc_pkg::CMD_INSERT, 8'd255);
        send_key(lebc_pkg::CMD_INSERT, 8'd32);
        send_key(lebc_pkg::CMD_INSERT, 8'd127);
        send_key(lebc_pkg::CMD_INSERT, 8'd65);
        repeat (4) send_key(lebc_pkg::CMD_LEFT, 8'd0);
        send_key(lebc_pkg::CMD_BACKSPACE, 8'd0);
        send_key(lebc_pkg::CMD_DELETE, 8'd0);
        repeat (3) send_key(lebc_pkg::CMD_RIGHT, 8'd0);
        send_key(lebc_pkg::CMD_DELETE, 8'd0);
        send_key(lebc_pkg::CMD_BACKSPACE, 8'd0);
        send_key(lebc_pkg::CMD_INSERT, 8'd122);
        send_key(lebc_pkg::CMD_COMMIT, 8'd0);
        send_key(lebc_pkg::CMD_INSERT, 8'd113);
        send_key(lebc_pkg::CMD_CANCEL, 8'd0);
        send_key(lebc_pkg::CMD_COMMIT, 8'd0);
        settle();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_team(team_plan[phase]);
            idle_pct <= (phase == 2) ? 0 : 15;
            if (phase == 1)
                hold_req <= 1'b1;
            if (phase == 1 || phase == 3)
                fill_line();
            repeat ((phase == 1 || phase == 3) ? 20 : 70)
            begin
                pick_key(c, k);
                send_key(c, k);
            end
            settle();
        end

        if (sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
